// ===== src/rfa_pkg.sv =====
// Package with the shared types, constants and helper function of the rational fraction ALU.
`default_nettype none
package rfa_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int MW = OPERAND_WIDTH;
    localparam int SW = MW + 1;
    localparam int PW = 2 * SW;
    localparam int RES_W = 64;
    localparam int DEN_W = 63;
    localparam int SUM_W = RES_W + 2;
    localparam int CNT_W = $clog2(MW + 1);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_SIMP  = 3'd4,
        OP_RECIP = 3'd5,
        OP_CMP   = 3'd6,
        OP_IDLE  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_GCD,
        S_GCD_WAIT,
        S_QN,
        S_QN_WAIT,
        S_QD,
        S_QD_WAIT,
        S_ALU,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] dividend;
        logic [MW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [MW-1:0] quotient;
        logic [MW-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic                 ok;
        logic signed [SW-1:0] num;
        logic signed [SW-1:0] den;
    } t_frac;

    function automatic t_frac normalise(input logic [31:0] n_in, input logic [31:0] d_in);
        t_frac f;
        f.num = SW'($signed(n_in[MW-1:0]));
        f.den = SW'($signed(d_in[MW-1:0]));
        f.ok  = (f.den != '0);
        if (f.num == '0) begin
            f.den = SW'(1);
        end else if (f.den < 0) begin
            f.num = -f.num;
            f.den = -f.den;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== src/rfa_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none
module rfa_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rfa_pkg::t_div_req i_req,
    output rfa_pkg::t_div_rsp      o_rsp
);
    import rfa_pkg::*;

    logic [MW:0]    r_rem;
    logic [MW-1:0]  r_quo;
    logic [MW-1:0]  r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [MW:0]    shifted;
    logic [MW:0]    diff;

    assign shifted = {r_rem[MW-1:0], r_quo[MW-1]};
    assign diff    = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[MW]) begin
                r_rem <= diff;
                r_quo <= {r_quo[MW-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[MW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[MW-1:0];

endmodule
`default_nettype wire

// ===== src/rational_fraction_alu_unit.sv =====
// Top level of the rational fraction ALU: sequencer, shared multiplier and result register.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | i_valid / o_ready   | i_op, i_a_num, i_a_den, i_b_num, i_b_den
//   output   | o_valid / i_ready   | o_r_num, o_r_den, o_status, o_cmp
//
// Add, subtract, multiply, divide and compare make three passes through the one
// shared signed multiplier, then take the combine and output steps.
// Reciprocal, errors, simplify of a zero numerator and the idle code go straight to those two steps.
// Simplify runs the Euclid remainder steps, each on the bit-serial divider, and then
// divides the numerator magnitude and the denominator by the gcd on the same divider.
// The block accepts a new transaction only while idle; a stalled result waits in the
// output register. Reset is synchronous and active low.
`default_nettype none
module rational_fraction_alu_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [31:0] i_a_num,
    input  wire logic [31:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [31:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_r_num,
    output logic [62:0]      o_r_den,
    output logic [1:0]       o_status,
    output logic [1:0]       o_cmp
);
    import rfa_pkg::*;

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_err;
    logic signed [SW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic [MW-1:0] r_x, r_y, r_qn, r_qd;
    logic [RES_W-1:0] r_rn;
    logic [DEN_W-1:0] r_rd;
    t_status r_st;
    t_cmp    r_cmp;
    logic    r_o_valid;

    t_frac fa, fb;
    t_op   in_op;
    logic  accept, need_b, in_err;
    logic  out_free;
    logic signed [SW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic [MW-1:0] mag_an;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [RES_W-1:0] alu_rn;
    logic [DEN_W-1:0] alu_rd;
    t_status alu_st;
    t_cmp    alu_cmp;
    logic signed [SUM_W-1:0] sum;
    logic signed [RES_W-1:0] narrow_sum;

    assign fa     = normalise(i_a_num, i_a_den);
    assign fb     = normalise(i_b_num, i_b_den);
    assign in_op  = t_op'(i_op);
    assign need_b = (in_op == OP_ADD) || (in_op == OP_SUB) || (in_op == OP_MUL) ||
                    (in_op == OP_DIV) || (in_op == OP_CMP);
    assign in_err = (in_op != OP_IDLE) && (!fa.ok || (need_b && !fb.ok));
    assign accept = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign mag_an = (r_an < 0) ? MW'(-r_an) : MW'(r_an);

    rfa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_err) begin
                        n_state = S_ALU;
                    end else begin
                        case (in_op) inside
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: n_state = S_MUL1;
                            OP_SIMP: n_state = (fa.num != '0) ? S_GCD : S_ALU;
                            default: n_state = S_ALU;
                        endcase
                    end
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_ALU;
            S_GCD: n_state = (r_y == '0) ? S_QN : S_GCD_WAIT;
            S_GCD_WAIT: if (div_rsp.done) n_state = S_GCD;
            S_QN: n_state = S_QN_WAIT;
            S_QN_WAIT: if (div_rsp.done) n_state = S_QD;
            S_QD: n_state = S_QD_WAIT;
            S_QD_WAIT: if (div_rsp.done) n_state = S_ALU;
            S_ALU: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        div_req = '0;
        mul_a   = r_ad;
        mul_b   = r_bd;
        unique case (r_state)
            S_MUL1: begin
                mul_a = r_an;
                mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            S_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_op == OP_MUL) ? r_bd : r_bn;
            end
            S_GCD: begin
                div_req.start    = (r_y != '0);
                div_req.dividend = r_x;
                div_req.divisor  = r_y;
            end
            S_QN: begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_an;
                div_req.divisor  = r_x;
            end
            S_QD: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_ad[MW-1:0];
                div_req.divisor  = r_x;
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        alu_rn  = '0;
        alu_rd  = DEN_W'(1);
        alu_st  = ST_OK;
        alu_cmp = CMP_LESS;
        narrow_sum = (r_op == OP_SUB) ? RES_W'(r_an) - RES_W'(r_bn)
                                      : RES_W'(r_an) + RES_W'(r_bn);
        sum = (r_op == OP_SUB) ? SUM_W'(r_p1) - SUM_W'(r_p2) : SUM_W'(r_p1) + SUM_W'(r_p2);
        if (r_err) begin
            alu_st = ST_ZERO_DEN;
        end else begin
            case (r_op) inside
                OP_ADD, OP_SUB: begin
                    if (r_ad == r_bd) begin
                        alu_rn = narrow_sum;
                        alu_rd = DEN_W'(r_ad);
                    end else if (sum[SUM_W-1:RES_W-1] != '0 && sum[SUM_W-1:RES_W-1] != '1) begin
                        alu_st = ST_OVERFLOW;
                    end else begin
                        alu_rn = sum[RES_W-1:0];
                        alu_rd = DEN_W'(r_p3);
                    end
                end
                OP_MUL: begin
                    alu_rn = RES_W'(r_p1);
                    alu_rd = DEN_W'(r_p2);
                end
                OP_DIV: begin
                    if (r_p2 == '0) begin
                        alu_st = ST_ZERO_DEN;
                    end else if (r_p2 < 0) begin
                        alu_rn = RES_W'(-r_p1);
                        alu_rd = DEN_W'(-r_p2);
                    end else begin
                        alu_rn = RES_W'(r_p1);
                        alu_rd = DEN_W'(r_p2);
                    end
                end
                OP_SIMP: begin
                    if (r_an != '0) begin
                        alu_rn = (r_an < 0) ? -RES_W'(r_qn) : RES_W'(r_qn);
                        alu_rd = DEN_W'(r_qd);
                    end
                end
                OP_RECIP: begin
                    if (r_an == '0) begin
                        alu_st = ST_ZERO_DEN;
                    end else begin
                        alu_rn = (r_an < 0) ? RES_W'(-r_ad) : RES_W'(r_ad);
                        alu_rd = DEN_W'(mag_an);
                    end
                end
                OP_CMP: begin
                    if (r_p1 < r_p2) begin
                        alu_cmp = CMP_LESS;
                    end else if (r_p1 == r_p2) begin
                        alu_cmp = CMP_EQUAL;
                    end else begin
                        alu_cmp = CMP_GREATER;
                    end
                end
                default: begin
                end
            endcase
        end
        if (alu_st != ST_OK) begin
            alu_rn = '0;
        end
        if (alu_rn == '0) begin
            alu_rd = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op  <= in_op;
                    r_err <= in_err;
                    r_an  <= fa.num;
                    r_ad  <= fa.den;
                    r_bn  <= fb.num;
                    r_bd  <= fb.den;
                    r_x   <= (fa.num < 0) ? MW'(-fa.num) : MW'(fa.num);
                    r_y   <= fa.den[MW-1:0];
                end
            end
            S_MUL1: r_p1 <= mul_p;
            S_MUL2: r_p2 <= mul_p;
            S_MUL3: r_p3 <= mul_p;
            S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    r_x <= r_y;
                    r_y <= div_rsp.remainder;
                end
            end
            S_QN_WAIT: if (div_rsp.done) r_qn <= div_rsp.quotient;
            S_QD_WAIT: if (div_rsp.done) r_qd <= div_rsp.quotient;
            S_ALU: begin
                r_rn  <= alu_rn;
                r_rd  <= alu_rd;
                r_st  <= alu_st;
                r_cmp <= alu_cmp;
            end
            S_DONE: begin
                if (out_free) begin
                    o_r_num  <= r_rn;
                    o_r_den  <= r_rd;
                    o_status <= r_st;
                    o_cmp    <= r_cmp;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_o_valid;

endmodule
`default_nettype wire
